// File: sv/bol_pkg.sv
// Package for the bounded ordered list: operation and status codes, shared types.
// No dependencies.
`timescale 1ns / 1ps

package bol_pkg;

  localparam int unsigned FuncW   = 3;
  localparam int unsigned PosW    = 4;
  localparam int unsigned WordW   = 64;
  localparam int unsigned StatusW = 2;
  localparam int unsigned CountW  = 5;

  localparam logic [FuncW-1:0] FuncPushFront = 3'd0;
  localparam logic [FuncW-1:0] FuncPushBack  = 3'd1;
  localparam logic [FuncW-1:0] FuncPopFront  = 3'd2;
  localparam logic [FuncW-1:0] FuncPopBack   = 3'd3;
  localparam logic [FuncW-1:0] FuncInsert    = 3'd4;
  localparam logic [FuncW-1:0] FuncErase     = 3'd5;

  localparam logic [StatusW-1:0] StDone  = 2'd0;
  localparam logic [StatusW-1:0] StFull  = 2'd1;
  localparam logic [StatusW-1:0] StEmpty = 2'd2;

  typedef enum logic [2:0] {
    OpNone,
    OpOpen,
    OpClose,
    OpWrite,
    OpDrop
  } op_e;

  // controller to datapath
  typedef struct packed {
    logic       run;
    op_e        op;
    logic [8:0] at;
  } cmd_t;

endpackage

// File: sv/bounded_ordered_list_core.sv
// Top level of the bounded ordered list. Depends on bol_pkg, bol_ctrl, bol_dp.
`timescale 1ns / 1ps

// Holds up to CAPACITY 64-bit words in order and applies one push, pop, insert-after
// or erase per item; an operation that does not fit is ignored and reported in
// status. For every item all slots shift in parallel in the accepting cycle and the
// result is registered, so it appears in the cycle after the item is accepted. The
// single output register sets the pace: a new item is accepted when that register is
// empty or its result is taken in the same cycle, and the input stalls while a
// result waits unaccepted. Slots beyond the count are never reported.
module bounded_ordered_list_core #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [bol_pkg::FuncW-1:0]   func_i,
  input  logic [bol_pkg::PosW-1:0]    position_i,
  input  logic [bol_pkg::WordW-1:0]   value_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [bol_pkg::StatusW-1:0] status_o,
  output logic [bol_pkg::CountW-1:0]  count_o,
  output logic [bol_pkg::WordW-1:0]   front_value_o,
  output logic [bol_pkg::WordW-1:0]   back_value_o
);

  localparam int unsigned CntW = $clog2(CAPACITY + 1) < 5 ? 5 : $clog2(CAPACITY + 1);

  bol_pkg::cmd_t   cmd;
  logic [CntW-1:0] cnt, cnt_d;
  logic            full;

  bol_ctrl #(.CntW(CntW)) u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .func_i, .position_i,
    .cnt_i(cnt), .full_i(full), .cmd_o(cmd), .cnt_d_o(cnt_d),
    .out_valid_o, .out_stall_i, .status_o
  );

  bol_dp #(.Cap(CAPACITY), .CntW(CntW)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .cnt_d_i(cnt_d), .value_i,
    .cnt_o(cnt), .full_o(full), .front_o(front_value_o), .back_o(back_value_o)
  );

  assign count_o = cnt[bol_pkg::CountW-1:0];

endmodule

// File: sv/bol_ctrl.sv
// Controller for the bounded ordered list: decodes an item, checks fit, drives
// the output register. Depends on bol_pkg.
`timescale 1ns / 1ps

module bol_ctrl #(
  parameter int unsigned CntW = 5
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [bol_pkg::FuncW-1:0]     func_i,
  input  logic [bol_pkg::PosW-1:0]      position_i,
  input  logic [CntW-1:0]               cnt_i,
  input  logic                          full_i,
  output bol_pkg::cmd_t                 cmd_o,
  output logic [CntW-1:0]               cnt_d_o,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [bol_pkg::StatusW-1:0]   status_o
);

  logic                        accept;
  logic                        pos_ok;
  logic [bol_pkg::StatusW-1:0] status_d, status_q;
  logic                        valid_q;

  assign in_stall_o = valid_q & out_stall_i;
  assign accept     = in_valid_i & ~in_stall_o;
  assign pos_ok     = CntW'(position_i) < cnt_i;

  always_comb begin
    cmd_o     = '{run: accept, op: bol_pkg::OpNone, at: '0};
    status_d  = bol_pkg::StDone;
    cnt_d_o   = cnt_i;
    case (func_i)
      bol_pkg::FuncPushFront: begin
        if (full_i) status_d = bol_pkg::StFull;
        else begin
          cmd_o.op = bol_pkg::OpOpen;
          cnt_d_o  = cnt_i + 1'b1;
        end
      end
      bol_pkg::FuncPushBack: begin
        if (full_i) status_d = bol_pkg::StFull;
        else begin
          cmd_o.op = bol_pkg::OpWrite;
          cmd_o.at = 9'(cnt_i);
          cnt_d_o  = cnt_i + 1'b1;
        end
      end
      bol_pkg::FuncPopFront: begin
        if (cnt_i == '0) status_d = bol_pkg::StEmpty;
        else begin
          cmd_o.op = bol_pkg::OpClose;
          cnt_d_o  = cnt_i - 1'b1;
        end
      end
      bol_pkg::FuncPopBack: begin
        if (cnt_i == '0) status_d = bol_pkg::StEmpty;
        else begin
          cmd_o.op = bol_pkg::OpDrop;
          cnt_d_o  = cnt_i - 1'b1;
        end
      end
      bol_pkg::FuncInsert: begin
        if (full_i) status_d = bol_pkg::StFull;
        else if (!pos_ok) status_d = bol_pkg::StEmpty;
        else begin
          cmd_o.op = bol_pkg::OpOpen;
          cmd_o.at = 9'(position_i) + 9'd1;
          cnt_d_o  = cnt_i + 1'b1;
        end
      end
      bol_pkg::FuncErase: begin
        if (!pos_ok) status_d = bol_pkg::StEmpty;
        else begin
          cmd_o.op = bol_pkg::OpClose;
          cmd_o.at = 9'(position_i);
          cnt_d_o  = cnt_i - 1'b1;
        end
      end
      default: status_d = bol_pkg::StEmpty;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= 1'b0;
      status_q <= bol_pkg::StDone;
    end else if (accept) begin
      valid_q  <= 1'b1;
      status_q <= status_d;
    end else if (!out_stall_i) begin
      valid_q  <= 1'b0;
    end
  end

  assign out_valid_o = valid_q;
  assign status_o    = status_q;

endmodule

// File: sv/bol_dp.sv
// Datapath for the bounded ordered list: slot array with parallel shift, count,
// front and back result registers. Depends on bol_pkg.
`timescale 1ns / 1ps

module bol_dp #(
  parameter int unsigned Cap  = 16,
  parameter int unsigned CntW = 5
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  bol_pkg::cmd_t               cmd_i,
  input  logic [CntW-1:0]             cnt_d_i,
  input  logic [bol_pkg::WordW-1:0]   value_i,
  output logic [CntW-1:0]             cnt_o,
  output logic                        full_o,
  output logic [bol_pkg::WordW-1:0]   front_o,
  output logic [bol_pkg::WordW-1:0]   back_o
);

  localparam int unsigned IdxW = (Cap > 1) ? $clog2(Cap) : 1;

  logic [bol_pkg::WordW-1:0] slot_q [Cap];
  logic [bol_pkg::WordW-1:0] slot_d [Cap];
  logic [CntW-1:0]           cnt_q;
  logic [bol_pkg::WordW-1:0] front_q, back_q;
  logic [CntW-1:0]           last_full;
  logic [IdxW-1:0]           last;

  assign full_o = cnt_q >= CntW'(Cap);
  assign cnt_o  = cnt_q;

  always_comb begin
    for (int i = 0; i < Cap; i++) begin
      slot_d[i] = slot_q[i];
      case (cmd_i.op)
        bol_pkg::OpOpen: begin
          if (i == int'(cmd_i.at)) slot_d[i] = value_i;
          else if (i > int'(cmd_i.at) && i > 0) slot_d[i] = slot_q[i-1];
        end
        bol_pkg::OpClose: begin
          if (i >= int'(cmd_i.at) && i + 1 < Cap) slot_d[i] = slot_q[i+1];
        end
        bol_pkg::OpWrite: begin
          if (i == int'(cmd_i.at)) slot_d[i] = value_i;
        end
        default: ;
      endcase
    end
  end

  assign last_full = cnt_d_i - 1'b1;
  assign last      = last_full[IdxW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) cnt_q <= '0;
    else if (cmd_i.run) cnt_q <= cnt_d_i;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.run) begin
      for (int i = 0; i < Cap; i++) slot_q[i] <= slot_d[i];
      front_q <= (cnt_d_i == '0) ? '0 : slot_d[0];
      back_q  <= (cnt_d_i == '0) ? '0 : slot_d[last];
    end
  end

  assign front_o = front_q;
  assign back_o  = back_q;

endmodule
